### design/tjs_pkg.sv
// Shared types and constants for the token join and split block.
package tjs_pkg;

   localparam int BYTE_W            = 8;
   localparam int SEP_BYTES         = 16;
   localparam int SEP_LEN_W         = 5;
   localparam int CSR_DATA_W        = 64;
   localparam int CSR_INDEX_W       = 2;
   localparam int SEPARATOR_MAX_DEF = 16;

   // Configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_DIRECTION = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SEP_LEN   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_SEP_LOW   = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_SEP_HIGH  = 2'd3;

   // Control from the sequencer to the pending window
   typedef struct packed {
      logic              append;
      logic              shift;
      logic [BYTE_W-1:0] data;
   } win_ctrl_type;

endpackage

### design/tjs_window.sv
// Pending window: candidate separator bytes of the current token.
module tjs_window #(
   parameter int DEPTH = tjs_pkg::SEPARATOR_MAX_DEF
) (
   input  logic                                         clock,
   input  tjs_pkg::win_ctrl_type                        ctrl,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_index,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_index,
   output logic [tjs_pkg::BYTE_W-1:0]                   head_byte,
   output logic [tjs_pkg::BYTE_W-1:0]                   rd_byte
);

   logic [tjs_pkg::BYTE_W-1:0] win_ff [DEPTH];
   logic [tjs_pkg::BYTE_W-1:0] win_in [DEPTH];

   always_comb begin
      win_in = win_ff;
      if (ctrl.append) begin
         win_in[wr_index] = ctrl.data;
      end else if (ctrl.shift) begin
         // drop the head, move the rest down one place
         for (int i = 0; i < DEPTH - 1; i++) begin
            win_in[i] = win_ff[i + 1];
         end
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

   assign head_byte = win_ff[0];
   assign rd_byte   = win_ff[rd_index];

endmodule

### design/token_join_split.sv
// Token join and split: whitespace-token join with separator, or split on separator.
// Sequence: accept in the idle state, then decode, then emit each result byte and close in
// the closing state (join: a whitespace byte emits nothing and goes straight to closing).
// Split compares the full window with the separator byte by byte, checks a short window,
// pops each flushed byte and ends a flush. Throughput: one transaction at a time.
// Synchronous reset: join with a space separator, message state cleared, window not reset.
module token_join_split #(
   parameter int SEPARATOR_MAX = tjs_pkg::SEPARATOR_MAX_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // input stream
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [tjs_pkg::BYTE_W-1:0]          req_tdata,   // [7:0] in_byte
   input  logic                                req_tlast,   // end_of_message
   // result stream
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [tjs_pkg::BYTE_W-1:0]          rsp_tdata,   // [7:0] out_byte
   output logic                                rsp_tuser,   // [0] byte_valid
   output logic                                rsp_tlast,   // last_of_message
   // configuration write port
   input  logic                                csr_wr_en,
   input  logic [tjs_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [tjs_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   // Window depth: the separator never exceeds the sixteen register bytes
   localparam int WIN_DEPTH = (SEPARATOR_MAX < tjs_pkg::SEP_BYTES) ?
                              SEPARATOR_MAX : tjs_pkg::SEP_BYTES;
   localparam int IDX_W     = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;
   localparam int PC_W      = $clog2(WIN_DEPTH + 1);
   localparam int LEN_W     = tjs_pkg::SEP_LEN_W;
   localparam int BW        = tjs_pkg::BYTE_W;
   localparam int CNT_W     = 4;

   localparam logic [BW-1:0] CHAR_SPACE = 8'h20;
   localparam logic [BW-1:0] CHAR_TAB   = 8'h09;
   localparam logic [BW-1:0] CHAR_LF    = 8'h0A;
   localparam logic [BW-1:0] CHAR_CR    = 8'h0D;

   // Sequencer states
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DECODE = 4'd1;
   localparam logic [3:0] S_SEP    = 4'd2;
   localparam logic [3:0] S_JBYTE  = 4'd3;
   localparam logic [3:0] S_EMPTY  = 4'd4;
   localparam logic [3:0] S_CHECK  = 4'd5;
   localparam logic [3:0] S_POP    = 4'd6;
   localparam logic [3:0] S_FLUSH  = 4'd7;
   localparam logic [3:0] S_FIN    = 4'd8;

   // Configuration registers
   logic                                dir_ff, dir_in;
   logic [LEN_W-1:0]                    seplen_ff, seplen_in;
   logic [tjs_pkg::CSR_DATA_W-1:0]      sep_lo_ff, sep_lo_in;
   logic [tjs_pkg::CSR_DATA_W-1:0]      sep_hi_ff, sep_hi_in;

   // Sequencer and message state
   logic [3:0]       state_ff, state_in;
   logic [BW-1:0]    byte_ff, byte_in;
   logic             last_ff, last_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             match_ff, match_in;
   logic             ret_flush_ff, ret_flush_in;
   logic [PC_W-1:0]  pc_ff, pc_in;
   logic             piece_open_ff, piece_open_in;
   logic             started_ff, started_in;
   logic             gap_ff, gap_in;

   // Staging slot: holds the newest result until it is known whether it ends the message
   logic             stage_v_ff, stage_v_in;
   logic [BW-1:0]    stage_byte_ff, stage_byte_in;

   // Output register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [BW-1:0]    rsp_byte_ff, rsp_byte_in;
   logic             rsp_bv_ff, rsp_bv_in;
   logic             rsp_last_ff, rsp_last_in;

   tjs_pkg::win_ctrl_type win_ctrl;
   logic [BW-1:0]         win_head;
   logic [BW-1:0]         win_rd;

   logic [2*tjs_pkg::CSR_DATA_W-1:0] sep_all;
   logic [BW-1:0]                    sep_byte;
   logic [LEN_W-1:0]                 l_eff;
   logic [LEN_W-1:0]                 l_last;
   logic                             is_ws;
   logic                             need_space;
   logic                             out_free;
   logic                             can_emit;
   logic                             emit;
   logic [BW-1:0]                    emit_data;
   logic                             byte_eq;

   tjs_window #(
      .DEPTH (WIN_DEPTH)
   ) u_window (
      .clock     (clock),
      .ctrl      (win_ctrl),
      .wr_index  (pc_ff[IDX_W-1:0]),
      .rd_index  (cnt_ff[IDX_W-1:0]),
      .head_byte (win_head),
      .rd_byte   (win_rd)
   );

   // Separator byte at the running index, and the length saturated to the window depth
   assign sep_all  = {sep_hi_ff, sep_lo_ff};
   assign sep_byte = sep_all[{cnt_ff, 3'b000} +: BW];
   assign l_eff    = (seplen_ff > LEN_W'(WIN_DEPTH)) ? LEN_W'(WIN_DEPTH) : seplen_ff;
   assign l_last   = l_eff - 1'b1;

   assign is_ws = (byte_ff == CHAR_SPACE) || (byte_ff == CHAR_TAB) ||
                  (byte_ff == CHAR_LF)    || (byte_ff == CHAR_CR);

   // A new piece after earlier output opens with a single space
   assign need_space = !piece_open_ff && started_ff;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign can_emit = !stage_v_ff || out_free;

   // The shared byte comparator: window entry against separator byte
   assign byte_eq = (win_rd == sep_byte);

   always_comb begin
      dir_in        = dir_ff;
      seplen_in     = seplen_ff;
      sep_lo_in     = sep_lo_ff;
      sep_hi_in     = sep_hi_ff;
      state_in      = state_ff;
      byte_in       = byte_ff;
      last_in       = last_ff;
      cnt_in        = cnt_ff;
      match_in      = match_ff;
      ret_flush_in  = ret_flush_ff;
      pc_in         = pc_ff;
      piece_open_in = piece_open_ff;
      started_in    = started_ff;
      gap_in        = gap_ff;
      stage_v_in    = stage_v_ff;
      stage_byte_in = stage_byte_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_byte_in   = rsp_byte_ff;
      rsp_bv_in     = rsp_bv_ff;
      rsp_last_in   = rsp_last_ff;
      win_ctrl      = '0;
      emit          = 1'b0;
      emit_data     = byte_ff;

      unique case (state_ff)
         S_IDLE: begin
            // take the next transaction
            if (req_tvalid) begin
               byte_in  = req_tdata;
               last_in  = req_tlast;
               state_in = S_DECODE;
            end
         end

         S_DECODE: begin
            cnt_in   = '0;
            match_in = 1'b1;
            if (!dir_ff) begin
               if (is_ws) begin
                  if (started_ff) gap_in = 1'b1;
                  state_in = S_FIN;
               end else if (started_ff && gap_ff && (l_eff != '0)) begin
                  state_in = S_SEP;
               end else begin
                  state_in = S_JBYTE;
               end
            end else if (is_ws) begin
               state_in = S_FLUSH;
            end else if (l_eff == '0) begin
               state_in = S_EMPTY;
            end else begin
               // append to the window, then hunt for a match
               win_ctrl.append = 1'b1;
               win_ctrl.data   = byte_ff;
               pc_in           = PC_W'(pc_ff + 1'b1);
               state_in        = S_CHECK;
            end
         end

         S_SEP: begin
            if (can_emit) begin
               emit      = 1'b1;
               emit_data = sep_byte;
               if ({1'b0, cnt_ff} == l_last) begin
                  cnt_in   = '0;
                  state_in = S_JBYTE;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end

         S_JBYTE: begin
            if (can_emit) begin
               emit       = 1'b1;
               emit_data  = byte_ff;
               gap_in     = 1'b0;
               started_in = 1'b1;
               state_in   = S_FIN;
            end
         end

         S_EMPTY: begin
            // empty separator: every character is a piece of its own
            if (can_emit) begin
               emit = 1'b1;
               if (need_space) begin
                  emit_data     = CHAR_SPACE;
                  piece_open_in = 1'b1;
               end else begin
                  emit_data     = byte_ff;
                  piece_open_in = 1'b0;
                  started_in    = 1'b1;
                  state_in      = last_ff ? S_FLUSH : S_FIN;
               end
            end
         end

         S_CHECK: begin
            if (LEN_W'(pc_ff) < l_eff) begin
               state_in = last_ff ? S_FLUSH : S_FIN;
            end else if ({1'b0, cnt_ff} == l_last) begin
               cnt_in   = '0;
               match_in = 1'b1;
               if (match_ff && byte_eq) begin
                  // separator found: drop it and close the piece
                  pc_in         = '0;
                  piece_open_in = 1'b0;
               end else begin
                  ret_flush_in = 1'b0;
                  state_in     = S_POP;
               end
            end else begin
               cnt_in   = cnt_ff + 1'b1;
               match_in = match_ff && byte_eq;
            end
         end

         S_POP: begin
            // commit the window head as a piece byte, after a space where a new piece needs one
            if (can_emit) begin
               emit          = 1'b1;
               piece_open_in = 1'b1;
               if (need_space) begin
                  emit_data = CHAR_SPACE;
               end else begin
                  emit_data      = win_head;
                  started_in     = 1'b1;
                  win_ctrl.shift = 1'b1;
                  pc_in          = PC_W'(pc_ff - 1'b1);
                  state_in       = ret_flush_ff ? S_FLUSH : S_CHECK;
               end
            end
         end

         S_FLUSH: begin
            if (pc_ff == '0) begin
               piece_open_in = 1'b0;
               state_in      = S_FIN;
            end else begin
               ret_flush_in = 1'b1;
               state_in     = S_POP;
            end
         end

         S_FIN: begin
            // hand the staged result over, flagged if it ends the message
            if (out_free) begin
               if (stage_v_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_byte_in  = stage_byte_ff;
                  rsp_bv_in    = 1'b1;
                  rsp_last_in  = last_ff;
                  stage_v_in   = 1'b0;
               end else if (last_ff) begin
                  // bare end marker
                  rsp_valid_in = 1'b1;
                  rsp_byte_in  = '0;
                  rsp_bv_in    = 1'b0;
                  rsp_last_in  = 1'b1;
               end
               if (last_ff) begin
                  pc_in         = '0;
                  piece_open_in = 1'b0;
                  started_in    = 1'b0;
                  gap_in        = 1'b0;
               end
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // advance the staging slot: the older result moves to the output register
      if (emit) begin
         if (stage_v_ff) begin
            rsp_valid_in = 1'b1;
            rsp_byte_in  = stage_byte_ff;
            rsp_bv_in    = 1'b1;
            rsp_last_in  = 1'b0;
         end
         stage_v_in    = 1'b1;
         stage_byte_in = emit_data;
      end

      // configuration write: update the register and drop the message state
      if (csr_wr_en) begin
         unique case (csr_index)
            tjs_pkg::REG_DIRECTION: dir_in    = csr_wdata[0];
            tjs_pkg::REG_SEP_LEN:   seplen_in = csr_wdata[LEN_W-1:0];
            tjs_pkg::REG_SEP_LOW:   sep_lo_in = csr_wdata;
            tjs_pkg::REG_SEP_HIGH:  sep_hi_in = csr_wdata;
            default: ;
         endcase
         pc_in         = '0;
         piece_open_in = 1'b0;
         started_in    = 1'b0;
         gap_in        = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff        <= 1'b0;
         seplen_ff     <= LEN_W'(1);
         sep_lo_ff     <= tjs_pkg::CSR_DATA_W'(CHAR_SPACE);
         sep_hi_ff     <= '0;
         state_ff      <= S_IDLE;
         last_ff       <= 1'b0;
         cnt_ff        <= '0;
         match_ff      <= 1'b1;
         ret_flush_ff  <= 1'b0;
         pc_ff         <= '0;
         piece_open_ff <= 1'b0;
         started_ff    <= 1'b0;
         gap_ff        <= 1'b0;
         stage_v_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         dir_ff        <= dir_in;
         seplen_ff     <= seplen_in;
         sep_lo_ff     <= sep_lo_in;
         sep_hi_ff     <= sep_hi_in;
         state_ff      <= state_in;
         last_ff       <= last_in;
         cnt_ff        <= cnt_in;
         match_ff      <= match_in;
         ret_flush_ff  <= ret_flush_in;
         pc_ff         <= pc_in;
         piece_open_ff <= piece_open_in;
         started_ff    <= started_in;
         gap_ff        <= gap_in;
         stage_v_ff    <= stage_v_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload: no reset needed
   always_ff @(posedge clock) begin
      byte_ff       <= byte_in;
      stage_byte_ff <= stage_byte_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_bv_ff     <= rsp_bv_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tuser  = rsp_bv_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
